// ===== hw/rtl/ffsa_pkg.sv =====
// Package: shared types and constants of the first-fit segment allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffsa_pkg;

    localparam int DEF_MAX_SEGMENTS = 64;
    localparam int DATA_W           = 32;
    localparam int CFG_IDX_W        = 2;
    localparam logic [DATA_W-1:0] TOTAL_SIZE_RST = 32'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOTAL_SIZE     = 2'd0,
        REG_ALIGNMENT_LOG2 = 2'd1
    } t_reg_idx;

    typedef enum logic {
        OP_ALLOCATE = 1'b0,
        OP_FREE     = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_SPACE    = 2'd1,
        ST_TABLE_FULL  = 2'd2,
        ST_UNKNOWN_OFF = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CM_HOLD,
        CM_ROTATE,
        CM_INIT,
        CM_UPDATE,
        CM_INSERT
    } t_cell_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_SCAN,
        S_DECIDE,
        S_MERGE,
        S_EDIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] off;
        logic [DATA_W-1:0] size;
        logic              free;
    } t_seg;

    typedef struct packed {
        t_cell_mode        mode;
        logic [1:0]        drop;
        logic [DATA_W-1:0] wr_size;
        logic              wr_free;
        logic [DATA_W-1:0] ins_off;
        logic [DATA_W-1:0] ins_size;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== hw/rtl/ffsa_req_if.sv =====
// Interface: request channel of the segment allocator.
`timescale 1ns / 1ps
`default_nettype none
interface ffsa_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] request_size;
    logic [31:0] release_offset;

    modport source (output valid, opcode, request_size, release_offset, input ready);
    modport sink   (input valid, opcode, request_size, release_offset, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ffsa_rsp_if.sv =====
// Interface: response channel of the segment allocator.
`timescale 1ns / 1ps
`default_nettype none
interface ffsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] granted_offset;
    logic [31:0] granted_size;

    modport source (output valid, status, granted_offset, granted_size, input ready);
    modport sink   (input valid, status, granted_offset, granted_size, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ffsa_cell.sv =====
// Module: one table cell of the segment ring, holding a single segment entry.
`timescale 1ns / 1ps
`default_nettype none
module ffsa_cell #(
    parameter int IDX_W = 6,
    parameter int IDX   = 0
) (
    input  wire                       i_clk,
    input  wire ffsa_pkg::t_cell_ctl  i_ctl,
    input  wire [IDX_W-1:0]           i_tgt,
    input  wire [IDX_W-1:0]           i_tgt1,
    input  wire ffsa_pkg::t_seg       i_up,
    input  wire ffsa_pkg::t_seg       i_up2,
    input  wire ffsa_pkg::t_seg       i_dn,
    output ffsa_pkg::t_seg            o_seg
);
    localparam logic [IDX_W-1:0] K = IDX_W'(IDX);

    ffsa_pkg::t_seg r_seg;

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.mode)
            ffsa_pkg::CM_HOLD: begin
            end
            ffsa_pkg::CM_ROTATE: begin
                r_seg <= i_up;
            end
            ffsa_pkg::CM_INIT: begin
                if (IDX == 0) begin
                    r_seg.off  <= '0;
                    r_seg.size <= i_ctl.wr_size;
                    r_seg.free <= 1'b1;
                end
            end
            ffsa_pkg::CM_UPDATE: begin
                if (K == i_tgt) begin
                    r_seg.size <= i_ctl.wr_size;
                    r_seg.free <= i_ctl.wr_free;
                end else if (K > i_tgt) begin
                    // close the gap left by merged neighbors
                    if (i_ctl.drop == 2'd1) begin
                        r_seg <= i_up;
                    end else if (i_ctl.drop == 2'd2) begin
                        r_seg <= i_up2;
                    end
                end
            end
            ffsa_pkg::CM_INSERT: begin
                if (K == i_tgt) begin
                    r_seg.size <= i_ctl.wr_size;
                    r_seg.free <= i_ctl.wr_free;
                end else if (K == i_tgt1) begin
                    r_seg.off  <= i_ctl.ins_off;
                    r_seg.size <= i_ctl.ins_size;
                    r_seg.free <= 1'b1;
                end else if (K > i_tgt1) begin
                    r_seg <= i_dn;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_seg = r_seg;
endmodule
`default_nettype wire

// ===== hw/rtl/first_fit_segment_allocator_top.sv =====
// Top level: first-fit segment allocator built on a ring of table cells.
//
//   channel   dir   handshake        beat contents
//   i_req     in    valid/ready      opcode, request_size, release_offset
//   o_rsp     out   valid/ready      status, granted_offset, granted_size
//   i_cfg_*   in    write enable     register index, 32-bit write data
//
// One request at a time: a new beat is taken only once the last one has
// left DONE. A free, and an allocate that passes the size checks, rotates the
// ring so that all cells pass the head cell; allocates of zero size or beyond
// the free space end before that scan. After reset or a total_size write the
// block loads cell 0 before it takes a beat. A finished beat waits in the
// output register; a stalled sink holds the sequencer in DONE.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_segment_allocator_top #(
    parameter int MAX_SEGMENTS = ffsa_pkg::DEF_MAX_SEGMENTS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    ffsa_req_if.sink                         i_req,
    ffsa_rsp_if.source                       o_rsp,
    input  wire                              i_cfg_we,
    input  wire [ffsa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [ffsa_pkg::DATA_W-1:0]       i_cfg_data
);
    localparam int N  = MAX_SEGMENTS;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam int DW = ffsa_pkg::DATA_W;

    // configuration and bookkeeping
    logic [DW-1:0] r_total;
    logic [4:0]    r_align;
    logic [CW-1:0] r_count;
    logic [DW-1:0] r_alloc;
    logic          r_init;

    ffsa_pkg::t_state r_state, n_state;

    // request held for the whole operation
    logic          r_op;
    logic [DW:0]   r_need;
    logic [DW-1:0] r_rel;

    // scan results
    logic [IW-1:0] r_step;
    logic          r_found;
    logic [IW-1:0] r_idx;
    logic [DW-1:0] r_off;
    logic [DW-1:0] r_sz;
    logic          r_last_free;
    logic [DW-1:0] r_last_sz;
    logic          r_prev_free;
    logic [DW-1:0] r_prev_sz;
    logic          r_look_next;
    logic          r_next_free;
    logic [DW-1:0] r_next_sz;
    logic          r_split;
    logic [DW-1:0] r_ins_off;
    logic [DW-1:0] r_ins_sz;
    logic [DW-1:0] r_acc;

    // pending response and output register
    logic [1:0]    r_res_status;
    logic [DW-1:0] r_res_off;
    logic [DW-1:0] r_res_sz;
    logic          r_out_valid;
    logic [1:0]    r_out_status;
    logic [DW-1:0] r_out_off;
    logic [DW-1:0] r_out_sz;

    // ring of cells
    ffsa_pkg::t_seg    w_seg [N];
    ffsa_pkg::t_cell_ctl w_ctl;
    logic [IW-1:0]     w_tgt;
    logic [IW-1:0]     w_tgt1;

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_cell
            ffsa_cell #(
                .IDX_W (IW),
                .IDX   (k)
            ) u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl),
                .i_tgt  (w_tgt),
                .i_tgt1 (w_tgt1),
                .i_up   (w_seg[(k + 1) % N]),
                .i_up2  (w_seg[(k + 2) % N]),
                .i_dn   (w_seg[(k + N - 1) % N]),
                .o_seg  (w_seg[k])
            );
        end
    endgenerate

    // head cell as seen during the scan; entry number equals r_step
    ffsa_pkg::t_seg w_head;
    logic           w_head_valid;
    assign w_head       = w_seg[0];
    assign w_head_valid = CW'(r_step) < r_count;

    // request rounding and free space
    logic [DW:0]   w_align_m1;
    logic [DW:0]   w_need;
    logic [DW-1:0] w_avail;
    assign w_align_m1 = ((DW + 1)'(1) << r_align) - (DW + 1)'(1);
    assign w_need     = ({1'b0, i_req.request_size} + w_align_m1) & ~w_align_m1;
    assign w_avail    = (r_alloc > r_total) ? '0 : (r_total - r_alloc);

    logic w_accept;
    logic w_out_free;
    assign i_req.ready = (r_state == ffsa_pkg::S_IDLE) && !r_init;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    logic w_alloc_hit;
    logic w_free_hit;
    assign w_alloc_hit = !r_found && w_head_valid && w_head.free
                         && ({1'b0, w_head.size} >= r_need);
    assign w_free_hit  = !r_found && w_head_valid && !w_head.free
                         && (w_head.off == r_rel);

    // next state and cell commands
    always_comb begin
        n_state        = r_state;
        w_ctl.mode     = ffsa_pkg::CM_HOLD;
        w_ctl.drop     = 2'd0;
        w_ctl.wr_size  = r_need[DW-1:0];
        w_ctl.wr_free  = 1'b0;
        w_ctl.ins_off  = r_ins_off;
        w_ctl.ins_size = r_ins_sz;
        w_tgt          = r_idx;
        w_tgt1         = r_idx + IW'(1);
        unique case (r_state)
            ffsa_pkg::S_IDLE: begin
                if (r_init) begin
                    w_ctl.mode    = ffsa_pkg::CM_INIT;
                    w_ctl.wr_size = r_total;
                end else if (w_accept) begin
                    n_state = (i_req.opcode == ffsa_pkg::OP_FREE) ? ffsa_pkg::S_SCAN
                                                                  : ffsa_pkg::S_PRE;
                end
            end
            ffsa_pkg::S_PRE: begin
                if (r_need == '0 || r_need > {1'b0, w_avail}) begin
                    n_state = ffsa_pkg::S_DONE;
                end else begin
                    n_state = ffsa_pkg::S_SCAN;
                end
            end
            ffsa_pkg::S_SCAN: begin
                w_ctl.mode = ffsa_pkg::CM_ROTATE;
                if (r_step == IW'(N - 1)) begin
                    n_state = ffsa_pkg::S_DECIDE;
                end
            end
            ffsa_pkg::S_DECIDE: begin
                if (!r_found) begin
                    n_state = ffsa_pkg::S_DONE;
                end else if (r_op == ffsa_pkg::OP_FREE) begin
                    n_state = ffsa_pkg::S_MERGE;
                end else if ({1'b0, r_sz} > r_need && r_count >= CW'(N)) begin
                    n_state = ffsa_pkg::S_DONE;
                end else begin
                    n_state = ffsa_pkg::S_EDIT;
                end
            end
            ffsa_pkg::S_MERGE: begin
                n_state = ffsa_pkg::S_EDIT;
            end
            ffsa_pkg::S_EDIT: begin
                if (r_op == ffsa_pkg::OP_FREE) begin
                    w_ctl.mode    = ffsa_pkg::CM_UPDATE;
                    w_ctl.wr_size = r_acc;
                    w_ctl.wr_free = 1'b1;
                    w_ctl.drop    = {1'b0, r_prev_free} + {1'b0, r_next_free};
                    w_tgt         = r_prev_free ? (r_idx - IW'(1)) : r_idx;
                end else if (r_split) begin
                    w_ctl.mode = ffsa_pkg::CM_INSERT;
                end else begin
                    w_ctl.mode = ffsa_pkg::CM_UPDATE;
                end
                n_state = ffsa_pkg::S_DONE;
            end
            ffsa_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = ffsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffsa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffsa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= ffsa_pkg::TOTAL_SIZE_RST;
            r_align     <= '0;
            r_count     <= CW'(1);
            r_alloc     <= '0;
            r_init      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ffsa_pkg::S_IDLE && r_init) begin
                r_init <= 1'b0;
            end
            if (r_state == ffsa_pkg::S_EDIT) begin
                if (r_op == ffsa_pkg::OP_FREE) begin
                    r_count <= r_count - CW'(r_prev_free) - CW'(r_next_free);
                    r_alloc <= r_alloc - r_sz;
                end else begin
                    if (r_split) begin
                        r_count <= r_count + CW'(1);
                    end
                    r_alloc <= r_alloc + r_need[DW-1:0];
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == ffsa_pkg::REG_TOTAL_SIZE) begin
                    r_total <= i_cfg_data;
                    r_count <= CW'(1);
                    r_alloc <= '0;
                    r_init  <= 1'b1;
                end else if (i_cfg_idx == ffsa_pkg::REG_ALIGNMENT_LOG2) begin
                    r_align <= i_cfg_data[4:0];
                end
            end
            if (r_state == ffsa_pkg::S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ffsa_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_op         <= i_req.opcode;
                    r_need       <= w_need;
                    r_rel        <= i_req.release_offset;
                    r_step       <= '0;
                    r_found      <= 1'b0;
                    r_last_free  <= 1'b0;
                    r_last_sz    <= '0;
                    r_look_next  <= 1'b0;
                    r_next_free  <= 1'b0;
                    r_next_sz    <= '0;
                    r_prev_free  <= 1'b0;
                    r_prev_sz    <= '0;
                    r_res_status <= ffsa_pkg::ST_UNKNOWN_OFF;
                    r_res_off    <= '0;
                    r_res_sz     <= '0;
                end
            end
            ffsa_pkg::S_PRE: begin
                r_res_status <= (r_need == '0) ? ffsa_pkg::ST_OK : ffsa_pkg::ST_NO_SPACE;
            end
            ffsa_pkg::S_SCAN: begin
                r_step      <= r_step + IW'(1);
                r_last_free <= w_head_valid && w_head.free;
                r_last_sz   <= w_head.size;
                r_look_next <= 1'b0;
                if (r_look_next) begin
                    r_next_free <= w_head_valid && w_head.free;
                    r_next_sz   <= w_head.size;
                end
                if ((r_op == ffsa_pkg::OP_FREE) ? w_free_hit : w_alloc_hit) begin
                    r_found     <= 1'b1;
                    r_idx       <= r_step;
                    r_off       <= w_head.off;
                    r_sz        <= w_head.size;
                    r_prev_free <= r_last_free;
                    r_prev_sz   <= r_last_sz;
                    r_look_next <= 1'b1;
                end
            end
            ffsa_pkg::S_DECIDE: begin
                r_split   <= {1'b0, r_sz} > r_need;
                r_ins_off <= r_off + r_need[DW-1:0];
                r_ins_sz  <= r_sz - r_need[DW-1:0];
                r_acc     <= r_sz + (r_next_free ? r_next_sz : '0);
                if (!r_found) begin
                    r_res_status <= (r_op == ffsa_pkg::OP_FREE) ? ffsa_pkg::ST_UNKNOWN_OFF
                                                                : ffsa_pkg::ST_NO_SPACE;
                end else if (r_op == ffsa_pkg::OP_ALLOCATE && {1'b0, r_sz} > r_need
                             && r_count >= CW'(N)) begin
                    r_res_status <= ffsa_pkg::ST_TABLE_FULL;
                end
            end
            ffsa_pkg::S_MERGE: begin
                r_acc <= r_acc + (r_prev_free ? r_prev_sz : '0);
            end
            ffsa_pkg::S_EDIT: begin
                r_res_status <= ffsa_pkg::ST_OK;
                r_res_off    <= (r_op == ffsa_pkg::OP_FREE) ? '0 : r_off;
                r_res_sz     <= (r_op == ffsa_pkg::OP_FREE) ? r_sz : r_need[DW-1:0];
            end
            ffsa_pkg::S_DONE: begin
                if (w_out_free) begin
                    r_out_status <= r_res_status;
                    r_out_off    <= r_res_off;
                    r_out_sz     <= r_res_sz;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.granted_offset = r_out_off;
    assign o_rsp.granted_size   = r_out_sz;
endmodule
`default_nettype wire
